/* src/ftq_pkg.sv */
// ----------------------------------------------------------------------------
// ftq_pkg
// Shared types and constants for the timer queue: sizes, operation and
// status codes, controller states and the controller command word.
// ----------------------------------------------------------------------------
package ftq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_WRAP     = 100000;

    localparam int TIME_W = 64;
    localparam int SEC_W  = 32;
    localparam int NSEC_W = 30;
    localparam int TAG_W  = 32;
    localparam int ID_W   = 17;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [NSEC_W-1:0] NS_PER_SEC = NSEC_W'(1000000000);
    localparam logic [ID_W-1:0]   ID_LAST    = ID_W'(ID_WRAP - 1);
    localparam logic [ID_W-1:0]   ID_FIRST   = ID_W'(1 % ID_WRAP);

    typedef enum logic [1:0] {
        OP_SET    = 2'd0,
        OP_CHECK  = 2'd1,
        OP_QUERY  = 2'd2,
        OP_CANCEL = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_EXPIRED   = 3'd1,
        ST_IDLE      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic capture;
        logic calc;
        logic exec;
    } cmd_t;

endpackage

/* src/ftq_ctrl.sv */
// ----------------------------------------------------------------------------
// ftq_ctrl
// Sequencer for one command: capture, precompute, execute.
// ----------------------------------------------------------------------------
module ftq_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output ftq_pkg::cmd_t cmd
);

    ftq_pkg::state_t state_reg;
    ftq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ftq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ftq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = ftq_pkg::S_CALC;
                end
            end
            ftq_pkg::S_CALC: state_next = ftq_pkg::S_EXEC;
            ftq_pkg::S_EXEC: state_next = ftq_pkg::S_IDLE;
            default:         state_next = ftq_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        busy        = 1'b1;
        cmd.capture = 1'b0;
        cmd.calc    = 1'b0;
        cmd.exec    = 1'b0;
        case (state_reg)
            ftq_pkg::S_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
            end
            ftq_pkg::S_CALC: cmd.calc = 1'b1;
            ftq_pkg::S_EXEC: cmd.exec = 1'b1;
            default:         busy     = 1'b1;
        endcase
    end

endmodule

/* src/ftq_datapath.sv */
// ----------------------------------------------------------------------------
// ftq_datapath
// Timer slots kept compacted with the head in slot 0, id counter, deadline
// arithmetic, id match row and the registered result word.
// ----------------------------------------------------------------------------
module ftq_datapath
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  ftq_pkg::cmd_t                cmd,
    input  logic [1:0]                   operation,
    input  logic [ftq_pkg::TIME_W-1:0]   now_ns,
    input  logic [ftq_pkg::SEC_W-1:0]    delay_sec,
    input  logic [ftq_pkg::NSEC_W-1:0]   delay_nsec,
    input  logic [ftq_pkg::TAG_W-1:0]    user_tag,
    input  logic [ftq_pkg::ID_W-1:0]     target_id,
    input  logic                         release_payload,
    output logic                         done,
    output logic [2:0]                   status,
    output logic [ftq_pkg::ID_W-1:0]     timer_id,
    output logic [ftq_pkg::TAG_W-1:0]    expired_tag,
    output logic [ftq_pkg::TIME_W-1:0]   remaining_ns,
    output logic                         payload_released
);

    localparam int DEPTH = ftq_pkg::QUEUE_DEPTH;

    // captured command word
    ftq_pkg::op_t                 op_reg;
    logic [ftq_pkg::TIME_W-1:0]   now_reg;
    logic [ftq_pkg::SEC_W-1:0]    sec_reg;
    logic [ftq_pkg::NSEC_W-1:0]   nsec_reg;
    logic [ftq_pkg::TAG_W-1:0]    tag_reg;
    logic [ftq_pkg::ID_W-1:0]     target_reg;
    logic                         release_reg;

    // precomputed terms
    logic [ftq_pkg::TIME_W-1:0]   prod_reg;
    logic [ftq_pkg::TIME_W-1:0]   base_reg;
    logic [ftq_pkg::TIME_W-1:0]   rem_reg;
    logic                         due_reg;
    logic [DEPTH-1:0]             match_reg;

    // queue state
    logic [ftq_pkg::TIME_W-1:0]   dl_reg  [DEPTH];
    logic [ftq_pkg::ID_W-1:0]     id_reg  [DEPTH];
    logic [ftq_pkg::TAG_W-1:0]    stag_reg[DEPTH];
    logic [ftq_pkg::CNT_W-1:0]    count_reg;
    logic [ftq_pkg::ID_W-1:0]     next_id_reg;

    // result word
    logic                         done_reg;
    ftq_pkg::status_t             status_reg;
    ftq_pkg::status_t             status_next;
    logic [ftq_pkg::ID_W-1:0]     id_out_reg;
    logic [ftq_pkg::ID_W-1:0]     id_out_next;
    logic [ftq_pkg::TAG_W-1:0]    tag_out_reg;
    logic [ftq_pkg::TAG_W-1:0]    tag_out_next;
    logic [ftq_pkg::TIME_W-1:0]   rem_out_reg;
    logic [ftq_pkg::TIME_W-1:0]   rem_out_next;
    logic                         rel_out_reg;
    logic                         rel_out_next;

    logic                         empty;
    logic                         full;
    logic                         found;
    logic                         seen;
    logic [DEPTH-1:0]             first_hot;
    logic [DEPTH-1:0]             after_hit;
    logic [DEPTH-1:0]             shift_mask;
    logic [ftq_pkg::ID_W-1:0]     hit_id;
    logic [ftq_pkg::TAG_W-1:0]    hit_tag;
    logic                         set_en;
    logic                         pop_en;
    logic                         cancel_en;
    logic                         shift_en;
    logic [ftq_pkg::TIME_W-1:0]   new_deadline;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == ftq_pkg::CNT_W'(DEPTH));
    assign found = |match_reg;

    // capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg      <= ftq_pkg::op_t'(operation);
            now_reg     <= now_ns;
            sec_reg     <= delay_sec;
            nsec_reg    <= delay_nsec;
            tag_reg     <= user_tag;
            target_reg  <= target_id;
            release_reg <= release_payload;
        end
    end

    // precompute: seconds scaling, head compare, id match row
    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            prod_reg <= ftq_pkg::TIME_W'(sec_reg) * ftq_pkg::TIME_W'(ftq_pkg::NS_PER_SEC);
            base_reg <= now_reg + ftq_pkg::TIME_W'(nsec_reg);
            due_reg  <= (dl_reg[0] <= now_reg);
            rem_reg  <= (dl_reg[0] > now_reg) ? (dl_reg[0] - now_reg) : '0;
        end
    end

    // first match from the head wins; entries at and above it move down
    always_comb
    begin
        seen    = 1'b0;
        hit_id  = '0;
        hit_tag = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            first_hot[i] = match_reg[i] & ~seen;
            seen         = seen | match_reg[i];
            after_hit[i] = seen;
            if (first_hot[i])
            begin
                hit_id  = hit_id | id_reg[i];
                hit_tag = hit_tag | stag_reg[i];
            end
        end
    end

    assign new_deadline = base_reg + prod_reg;
    assign set_en    = cmd.exec && (op_reg == ftq_pkg::OP_SET) && !full;
    assign pop_en    = cmd.exec && (op_reg == ftq_pkg::OP_CHECK) && !empty && due_reg;
    assign cancel_en = cmd.exec && (op_reg == ftq_pkg::OP_CANCEL) && found;
    assign shift_en  = pop_en || cancel_en;
    assign shift_mask = pop_en ? {DEPTH{1'b1}} : after_hit;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_slot
            always_ff @(posedge clk)
            begin
                if (cmd.calc)
                begin
                    match_reg[gi] <= (ftq_pkg::CNT_W'(gi) < count_reg)
                                     && (id_reg[gi] == target_reg);
                end
            end

            if (gi < DEPTH - 1)
            begin : g_move
                always_ff @(posedge clk)
                begin
                    if (shift_en && shift_mask[gi])
                    begin
                        dl_reg[gi]   <= dl_reg[gi+1];
                        id_reg[gi]   <= id_reg[gi+1];
                        stag_reg[gi] <= stag_reg[gi+1];
                    end
                    else if (set_en && (count_reg == ftq_pkg::CNT_W'(gi)))
                    begin
                        dl_reg[gi]   <= new_deadline;
                        id_reg[gi]   <= next_id_reg;
                        stag_reg[gi] <= tag_reg;
                    end
                end
            end
            else
            begin : g_tail
                always_ff @(posedge clk)
                begin
                    if (set_en && (count_reg == ftq_pkg::CNT_W'(gi)))
                    begin
                        dl_reg[gi]   <= new_deadline;
                        id_reg[gi]   <= next_id_reg;
                        stag_reg[gi] <= tag_reg;
                    end
                end
            end
        end
    endgenerate

    // occupancy and id counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            next_id_reg <= ftq_pkg::ID_FIRST;
        end
        else
        begin
            if (set_en)
            begin
                count_reg   <= count_reg + 1'b1;
                next_id_reg <= (next_id_reg == ftq_pkg::ID_LAST) ? '0 : next_id_reg + 1'b1;
            end
            else if (shift_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // result word
    always_comb
    begin
        status_next  = ftq_pkg::ST_DONE;
        id_out_next  = '0;
        tag_out_next = '0;
        rem_out_next = '0;
        rel_out_next = 1'b0;
        case (op_reg)
            ftq_pkg::OP_SET:
            begin
                if (full)
                begin
                    status_next = ftq_pkg::ST_FULL;
                end
                else
                begin
                    id_out_next = next_id_reg;
                end
            end
            ftq_pkg::OP_CHECK:
            begin
                if (empty || !due_reg)
                begin
                    status_next = ftq_pkg::ST_IDLE;
                end
                else
                begin
                    status_next  = ftq_pkg::ST_EXPIRED;
                    id_out_next  = id_reg[0];
                    tag_out_next = stag_reg[0];
                end
            end
            ftq_pkg::OP_QUERY:
            begin
                if (empty)
                begin
                    status_next = ftq_pkg::ST_IDLE;
                end
                else
                begin
                    rem_out_next = rem_reg;
                end
            end
            ftq_pkg::OP_CANCEL:
            begin
                if (found)
                begin
                    id_out_next  = hit_id;
                    tag_out_next = hit_tag;
                    rel_out_next = release_reg;
                end
                else
                begin
                    status_next = ftq_pkg::ST_NOT_FOUND;
                end
            end
            default: status_next = ftq_pkg::ST_NOT_FOUND;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.exec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg  <= status_next;
            id_out_reg  <= id_out_next;
            tag_out_reg <= tag_out_next;
            rem_out_reg <= rem_out_next;
            rel_out_reg <= rel_out_next;
        end
    end

    assign done             = done_reg;
    assign status           = status_reg;
    assign timer_id         = id_out_reg;
    assign expired_tag      = tag_out_reg;
    assign remaining_ns     = rem_out_reg;
    assign payload_released = rel_out_reg;

endmodule

/* src/fifo_timeout_queue.sv */
// ----------------------------------------------------------------------------
// fifo_timeout_queue
// Insertion-ordered timer queue with set, head expiry check, remaining-time
// query and cancel by id.
// ----------------------------------------------------------------------------
// Usage:
//   Drive operation and its operand ports with start high; the word is taken
//   at a clock edge where start is high and busy is low. busy then stays high
//   while the command runs through the precompute and execute states.
//   Each command gives exactly one result word, shown on status, timer_id,
//   expired_tag, remaining_ns and payload_released for one cycle with done
//   high. done rises once the command has passed the precompute and execute
//   states and the result register; busy is already low in that cycle, so a
//   new command may be taken then. No new command is taken before the last
//   has run the capture, precompute, execute sequence (the seconds multiply
//   and the id match row are registered before the queue update).
//   The receiver has no stall: the result word must be taken while done is
//   high.
//   Reset empties the queue and sets the next id to 1; slot contents are
//   left as they are and never read until written.
//   Fields that carry no meaning for a given result are zero.
// ----------------------------------------------------------------------------
module fifo_timeout_queue
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   operation,
    input  logic [ftq_pkg::TIME_W-1:0]   now_ns,
    input  logic [ftq_pkg::SEC_W-1:0]    delay_sec,
    input  logic [ftq_pkg::NSEC_W-1:0]   delay_nsec,
    input  logic [ftq_pkg::TAG_W-1:0]    user_tag,
    input  logic [ftq_pkg::ID_W-1:0]     target_id,
    input  logic                         release_payload,
    output logic                         done,
    output logic [2:0]                   status,
    output logic [ftq_pkg::ID_W-1:0]     timer_id,
    output logic [ftq_pkg::TAG_W-1:0]    expired_tag,
    output logic [ftq_pkg::TIME_W-1:0]   remaining_ns,
    output logic                         payload_released
);

    // command word from the sequencer to the datapath
    ftq_pkg::cmd_t cmd;

    ftq_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    // queue slots, deadline math and result register
    ftq_datapath u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .operation        (operation),
        .now_ns           (now_ns),
        .delay_sec        (delay_sec),
        .delay_nsec       (delay_nsec),
        .user_tag         (user_tag),
        .target_id        (target_id),
        .release_payload  (release_payload),
        .done             (done),
        .status           (status),
        .timer_id         (timer_id),
        .expired_tag      (expired_tag),
        .remaining_ns     (remaining_ns),
        .payload_released (payload_released)
    );

endmodule
